// ===== hw/rtl/rdcs_pkg.sv =====
// Shared types, constants and helpers for the rolling digit clock sequencer.
package rdcs_pkg;

    localparam int NUM_SLOTS     = 4;
    localparam int SLOT_W        = 2;
    localparam int IDX_W         = 4;
    localparam int CHAR_W        = 4;
    localparam int FRAME_W       = 3;
    localparam int HOURS_W       = 5;
    localparam int MINUTES_W     = 6;
    localparam int FMT_W         = 2;
    localparam int MAX_STEPS_DEF = 8;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0]    CODE_BLANK  = 4'd10;
    localparam logic [FMT_W-1:0]     FMT_24H     = 2'd0;
    localparam logic [FMT_W-1:0]     FMT_12H_ZERO = 2'd1;
    localparam logic                 KIND_STATUS = 1'b0;
    localparam logic                 KIND_DRAW   = 1'b1;
    localparam logic [HOURS_W-1:0]   HOURS_MAX   = 5'd23;
    localparam logic [MINUTES_W-1:0] MINUTES_MAX = 6'd59;
    localparam logic [HOURS_W-1:0]   HALF_DAY    = 5'd12;
    localparam logic [FRAME_W-1:0]   FRAME_MAX   = 3'd7;
    localparam logic [SLOT_W-1:0]    SLOT_HOUR_TENS = 2'd0;

    typedef enum logic [1:0] {
        MODE_SET    = 2'd0,
        MODE_UPDATE = 2'd1,
        MODE_STEP   = 2'd2,
        MODE_REDRAW = 2'd3
    } t_mode;

    // One classified item as it waits between front and back.
    typedef struct packed {
        t_mode                             mode;
        logic [NUM_SLOTS-1:0][IDX_W-1:0]   digits;
    } t_cmd;

    typedef struct packed {
        logic                 kind;
        logic                 clear_screen;
        logic [SLOT_W-1:0]    digit_slot;
        logic [CHAR_W-1:0]    shown_char;
        logic [CHAR_W-1:0]    target_char;
        logic [FRAME_W-1:0]   frame;
        logic                 rolling;
        logic                 last;
    } t_result;

    // Image code of a digit index; hour tens depends on the display format.
    function automatic logic [CHAR_W-1:0] code_of(
        input logic [SLOT_W-1:0] slot,
        input logic [IDX_W-1:0]  idx,
        input logic [FMT_W-1:0]  fmt
    );
        logic [CHAR_W-1:0] code;
        code = CODE_BLANK;
        if (slot != SLOT_HOUR_TENS) begin
            if (idx <= 4'd9) code = idx;
        end else if (fmt == FMT_24H) begin
            if (idx <= 4'd2) code = idx;
        end else if (fmt == FMT_12H_ZERO) begin
            if (idx <= 4'd1) code = idx;
        end else begin
            if (idx == 4'd1) code = 4'd1;
        end
        return code;
    endfunction

endpackage

// ===== hw/rtl/rdcs_front.sv =====
// Front end: accepts input beats and turns a time into four digit indices.
module rdcs_front (
    input  logic                             i_valid,
    input  rdcs_pkg::t_mode                  i_mode,
    input  logic [rdcs_pkg::HOURS_W-1:0]     i_hours,
    input  logic [rdcs_pkg::MINUTES_W-1:0]   i_minutes,
    input  logic [rdcs_pkg::FMT_W-1:0]       i_fmt,
    input  logic                             i_full,
    output logic                             o_ready,
    output logic                             o_push,
    output rdcs_pkg::t_cmd                   o_cmd
);

    logic [rdcs_pkg::HOURS_W-1:0]   hours_sat;
    logic [rdcs_pkg::HOURS_W-1:0]   hours_adj;
    logic [rdcs_pkg::MINUTES_W-1:0] minutes_sat;
    logic [1:0]                     hour_tens;
    logic [2:0]                     min_tens;
    logic [rdcs_pkg::HOURS_W-1:0]   hour_units;
    logic [rdcs_pkg::MINUTES_W-1:0] min_units;

    always_comb begin
        hours_sat = (i_hours > rdcs_pkg::HOURS_MAX) ? rdcs_pkg::HOURS_MAX : i_hours;
        minutes_sat = (i_minutes > rdcs_pkg::MINUTES_MAX) ? rdcs_pkg::MINUTES_MAX : i_minutes;

        hours_adj = hours_sat;
        if (i_fmt != rdcs_pkg::FMT_24H) begin
            if (hours_adj > rdcs_pkg::HALF_DAY) hours_adj = hours_adj - rdcs_pkg::HALF_DAY;
            if (hours_adj == '0) hours_adj = rdcs_pkg::HALF_DAY;
        end

        // values stay below 24 and 60: tens by compare ladder
        if (hours_adj >= 5'd20)      hour_tens = 2'd2;
        else if (hours_adj >= 5'd10) hour_tens = 2'd1;
        else                         hour_tens = 2'd0;

        if (minutes_sat >= 6'd50)      min_tens = 3'd5;
        else if (minutes_sat >= 6'd40) min_tens = 3'd4;
        else if (minutes_sat >= 6'd30) min_tens = 3'd3;
        else if (minutes_sat >= 6'd20) min_tens = 3'd2;
        else if (minutes_sat >= 6'd10) min_tens = 3'd1;
        else                           min_tens = 3'd0;

        hour_units = hours_adj - 5'(hour_tens * 4'd10);
        min_units  = minutes_sat - 6'(min_tens * 6'd10);

        o_cmd.mode      = i_mode;
        o_cmd.digits[0] = 4'(hour_tens);
        o_cmd.digits[1] = hour_units[3:0];
        o_cmd.digits[2] = 4'(min_tens);
        o_cmd.digits[3] = min_units[3:0];
    end

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

endmodule

// ===== hw/rtl/rdcs_queue.sv =====
// Short command queue between front and back ends.
module rdcs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rdcs_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output rdcs_pkg::t_cmd  o_cmd
);

    rdcs_pkg::t_cmd                r_mem [rdcs_pkg::QUEUE_DEPTH];
    logic [rdcs_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [rdcs_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [rdcs_pkg::QCNT_W-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_cmd;
    end

    assign o_full  = (r_count == rdcs_pkg::QCNT_W'(rdcs_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

endmodule

// ===== hw/rtl/rdcs_back.sv =====
// Back end: digit state, step and redraw sequencing, result output register.
module rdcs_back #(
    parameter int MAX_STEPS = rdcs_pkg::MAX_STEPS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  rdcs_pkg::t_cmd              i_cmd,
    input  logic [rdcs_pkg::FMT_W-1:0]  i_fmt,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output rdcs_pkg::t_result           o_result
);

    localparam int CNT_W = $clog2(MAX_STEPS);

    logic [rdcs_pkg::IDX_W-1:0] r_shown  [rdcs_pkg::NUM_SLOTS];
    logic [rdcs_pkg::IDX_W-1:0] r_target [rdcs_pkg::NUM_SLOTS];
    logic [CNT_W-1:0]           r_frame  [rdcs_pkg::NUM_SLOTS];
    logic                       r_rolling;
    logic [rdcs_pkg::SLOT_W-1:0] r_beat;
    logic                       r_valid;
    rdcs_pkg::t_result          r_result;

    logic [rdcs_pkg::IDX_W-1:0] n_shown  [rdcs_pkg::NUM_SLOTS];
    logic [rdcs_pkg::IDX_W-1:0] n_target [rdcs_pkg::NUM_SLOTS];
    logic [CNT_W-1:0]           n_frame  [rdcs_pkg::NUM_SLOTS];
    logic                       n_rolling;
    rdcs_pkg::t_result          res;

    logic                        advance;
    logic                        found;
    logic [rdcs_pkg::SLOT_W-1:0] sel;
    logic [CNT_W:0]              inc;
    logic                        beat_last;

    function automatic logic [rdcs_pkg::FRAME_W-1:0] frame_sat(input logic [CNT_W-1:0] cnt);
        if (32'(cnt) > 32'(rdcs_pkg::FRAME_MAX)) return rdcs_pkg::FRAME_MAX;
        return rdcs_pkg::FRAME_W'(cnt);
    endfunction

    assign advance   = i_cmd_valid && (!r_valid || i_ready);
    assign beat_last = (r_beat == rdcs_pkg::SLOT_W'(rdcs_pkg::NUM_SLOTS - 1));
    assign o_pop     = advance && ((i_cmd.mode != rdcs_pkg::MODE_REDRAW) || beat_last);

    always_comb begin
        n_shown   = r_shown;
        n_target  = r_target;
        n_frame   = r_frame;
        n_rolling = r_rolling;
        res       = '0;
        inc       = '0;

        // highest slot that differs goes first
        found = 1'b0;
        sel   = '0;
        for (int s = 0; s < rdcs_pkg::NUM_SLOTS; s++) begin
            if (r_shown[s] != r_target[s]) begin
                found = 1'b1;
                sel   = rdcs_pkg::SLOT_W'(s);
            end
        end

        case (i_cmd.mode)
            rdcs_pkg::MODE_SET, rdcs_pkg::MODE_UPDATE: begin
                for (int s = 0; s < rdcs_pkg::NUM_SLOTS; s++) begin
                    n_target[s] = i_cmd.digits[s];
                    if (i_cmd.mode == rdcs_pkg::MODE_SET) n_shown[s] = i_cmd.digits[s];
                    n_frame[s] = '0;
                end
                n_rolling   = (i_cmd.mode == rdcs_pkg::MODE_UPDATE);
                res.kind    = rdcs_pkg::KIND_STATUS;
                res.rolling = n_rolling;
                res.last    = 1'b1;
            end
            rdcs_pkg::MODE_STEP: begin
                if (found) begin
                    inc = {1'b0, r_frame[sel]} + 1'b1;
                    if (inc >= (CNT_W+1)'(MAX_STEPS)) begin
                        n_shown[sel] = r_target[sel];
                        n_frame[sel] = '0;
                    end else begin
                        n_frame[sel] = inc[CNT_W-1:0];
                    end
                    res.kind        = rdcs_pkg::KIND_DRAW;
                    res.digit_slot  = sel;
                    res.shown_char  = rdcs_pkg::code_of(sel, n_shown[sel], i_fmt);
                    res.target_char = rdcs_pkg::code_of(sel, r_target[sel], i_fmt);
                    res.frame       = frame_sat(n_frame[sel]);
                    res.rolling     = r_rolling;
                    res.last        = 1'b1;
                end else begin
                    n_rolling   = 1'b0;
                    res.kind    = rdcs_pkg::KIND_STATUS;
                    res.rolling = 1'b0;
                    res.last    = 1'b1;
                end
            end
            rdcs_pkg::MODE_REDRAW: begin
                res.kind         = rdcs_pkg::KIND_DRAW;
                res.clear_screen = (r_beat == '0);
                res.digit_slot   = r_beat;
                res.shown_char   = rdcs_pkg::code_of(r_beat, r_shown[r_beat], i_fmt);
                res.target_char  = rdcs_pkg::code_of(r_beat, r_target[r_beat], i_fmt);
                res.frame        = frame_sat(r_frame[r_beat]);
                res.rolling      = r_rolling;
                res.last         = beat_last;
            end
            default: begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < rdcs_pkg::NUM_SLOTS; s++) begin
                r_shown[s]  <= '0;
                r_target[s] <= '0;
                r_frame[s]  <= '0;
            end
            r_rolling <= 1'b0;
            r_beat    <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (advance) begin
                r_shown   <= n_shown;
                r_target  <= n_target;
                r_frame   <= n_frame;
                r_rolling <= n_rolling;
                r_valid   <= 1'b1;
                if (i_cmd.mode == rdcs_pkg::MODE_REDRAW) begin
                    r_beat <= beat_last ? '0 : r_beat + 1'b1;
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) r_result <= res;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== hw/rtl/rolling_digit_clock_sequencer.sv =====
// Top level of the rolling digit clock sequencer: ports, format register, front/queue/back.
//
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   tuser: mode; tdata: hours, minutes
//  m_*       out  m_tvalid/m_tready   tuser: kind; tdata: draw fields; tlast: last
//  apb       in   psel/penable/pready display_format at byte address 0
//
// Set, update and step items give one beat each in the back end; redraw gives four
// beats, one beat per cycle while m_tready allows, bound by the single output register.
// The front accepts a beat in every cycle while the two-entry queue has room.
// Reset is synchronous and clears digit state, queue and output at once.
// A stalled m_tready holds the output register; the queue then fills and s_tready drops.
module rolling_digit_clock_sequencer #(
    parameter int MAX_STEPS = rdcs_pkg::MAX_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // hours[4:0], minutes[10:5], zero pad
    input  logic [1:0]  s_tuser,   // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // clear_screen[0], digit_slot[2:1], shown_char[6:3],
                                   // target_char[10:7], frame[13:11], rolling[14], pad
    output logic        m_tuser,   // kind[0]
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [rdcs_pkg::FMT_W-1:0] r_format;
    logic                       q_full;
    logic                       q_valid;
    logic                       push;
    logic                       pop;
    rdcs_pkg::t_cmd             front_cmd;
    rdcs_pkg::t_cmd             back_cmd;
    rdcs_pkg::t_result          result;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= rdcs_pkg::FMT_24H;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_format <= pwdata[rdcs_pkg::FMT_W-1:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : 32'(r_format);

    rdcs_front u_front (
        .i_valid   (s_tvalid),
        .i_mode    (rdcs_pkg::t_mode'(s_tuser)),
        .i_hours   (s_tdata[4:0]),
        .i_minutes (s_tdata[10:5]),
        .i_fmt     (r_format),
        .i_full    (q_full),
        .o_ready   (s_tready),
        .o_push    (push),
        .o_cmd     (front_cmd)
    );

    rdcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (back_cmd)
    );

    rdcs_back #(
        .MAX_STEPS (MAX_STEPS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (back_cmd),
        .i_fmt       (r_format),
        .o_pop       (pop),
        .o_valid     (m_tvalid),
        .i_ready     (m_tready),
        .o_result    (result)
    );

    assign m_tdata = {1'b0, result.rolling, result.frame, result.target_char,
                      result.shown_char, result.digit_slot, result.clear_screen};
    assign m_tuser = result.kind;
    assign m_tlast = result.last;

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the rolling digit clock sequencer.
`timescale 1ns / 1ps

module tb_top;

    localparam int          ROLL_STEPS  = rdcs_pkg::MAX_STEPS_DEF;
    localparam logic [2:0]  ADDR_FORMAT = 3'd0;
    localparam logic [rdcs_pkg::FMT_W-1:0] FMT_12H_BLANK = 2'd2;
    localparam logic [rdcs_pkg::FMT_W-1:0] FMT_ALIAS     = 2'd3;

    // Expected-beat store plus a model of the four digit slots.
    class digit_roll_scoreboard;
        logic [rdcs_pkg::IDX_W-1:0]  shown_idx [rdcs_pkg::NUM_SLOTS];
        logic [rdcs_pkg::IDX_W-1:0]  target_idx[rdcs_pkg::NUM_SLOTS];
        int unsigned                 frames    [rdcs_pkg::NUM_SLOTS];
        bit                          rolling;
        logic [rdcs_pkg::FMT_W-1:0]  fmt;
        rdcs_pkg::t_result           expected_beats[$];
        int                          mismatches;

        function new();
            for (int s = 0; s < rdcs_pkg::NUM_SLOTS; s++) begin
                shown_idx[s]  = '0;
                target_idx[s] = '0;
                frames[s]     = 0;
            end
            rolling    = 1'b0;
            fmt        = rdcs_pkg::FMT_24H;
            mismatches = 0;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("MISMATCH: %s", msg);
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        function logic [rdcs_pkg::CHAR_W-1:0] char_code(int slot,
                                                        logic [rdcs_pkg::IDX_W-1:0] idx);
            if (slot != 0) return (idx <= 9) ? idx : rdcs_pkg::CODE_BLANK;
            case (fmt)
                rdcs_pkg::FMT_24H:      return (idx <= 2) ? idx : rdcs_pkg::CODE_BLANK;
                rdcs_pkg::FMT_12H_ZERO: return (idx <= 1) ? idx : rdcs_pkg::CODE_BLANK;
                default:                return (idx == 1) ? 4'd1 : rdcs_pkg::CODE_BLANK;
            endcase
        endfunction

        function rdcs_pkg::t_result draw_beat(int slot, bit clr, bit lst);
            rdcs_pkg::t_result r;
            r.kind         = rdcs_pkg::KIND_DRAW;
            r.clear_screen = clr;
            r.digit_slot   = slot[rdcs_pkg::SLOT_W-1:0];
            r.shown_char   = char_code(slot, shown_idx[slot]);
            r.target_char  = char_code(slot, target_idx[slot]);
            r.frame        = (frames[slot] > 7) ? rdcs_pkg::FRAME_MAX
                                                : frames[slot][rdcs_pkg::FRAME_W-1:0];
            r.rolling      = rolling;
            r.last         = lst;
            return r;
        endfunction

        function rdcs_pkg::t_result status_beat();
            rdcs_pkg::t_result r;
            r         = '0;
            r.kind    = rdcs_pkg::KIND_STATUS;
            r.rolling = rolling;
            r.last    = 1'b1;
            return r;
        endfunction

        function void load_clock(int hrs, int mins, bit jump);
            int h;
            int m;
            logic [rdcs_pkg::IDX_W-1:0] dig[rdcs_pkg::NUM_SLOTS];
            h = (hrs > 23) ? 23 : hrs;
            m = (mins > 59) ? 59 : mins;
            if (fmt != rdcs_pkg::FMT_24H) begin
                if (h > 12) h -= 12;
                if (h == 0) h = 12;
            end
            dig[0] = rdcs_pkg::IDX_W'(h / 10);
            dig[1] = rdcs_pkg::IDX_W'(h % 10);
            dig[2] = rdcs_pkg::IDX_W'(m / 10);
            dig[3] = rdcs_pkg::IDX_W'(m % 10);
            for (int s = 0; s < rdcs_pkg::NUM_SLOTS; s++) begin
                target_idx[s] = dig[s];
                if (jump) shown_idx[s] = dig[s];
                frames[s] = 0;
            end
            rolling = !jump;
        endfunction

        function void note_item(rdcs_pkg::t_mode md, logic [rdcs_pkg::HOURS_W-1:0] hrs,
                                logic [rdcs_pkg::MINUTES_W-1:0] mins);
            case (md)
                rdcs_pkg::MODE_SET, rdcs_pkg::MODE_UPDATE: begin
                    load_clock(hrs, mins, md == rdcs_pkg::MODE_SET);
                    expected_beats.push_back(status_beat());
                end
                rdcs_pkg::MODE_STEP: begin
                    // slot 3 is minute units and goes first, so scan from slot 3 down
                    for (int s = rdcs_pkg::NUM_SLOTS - 1; s >= 0; s--) begin
                        if (shown_idx[s] != target_idx[s]) begin
                            frames[s]++;
                            if (frames[s] >= ROLL_STEPS) begin
                                shown_idx[s] = target_idx[s];
                                frames[s]    = 0;
                            end
                            expected_beats.push_back(draw_beat(s, 1'b0, 1'b1));
                            return;
                        end
                    end
                    rolling = 1'b0;
                    expected_beats.push_back(status_beat());
                end
                default: begin
                    for (int s = 0; s < rdcs_pkg::NUM_SLOTS; s++)
                        expected_beats.push_back(draw_beat(s, s == 0,
                                                           s == rdcs_pkg::NUM_SLOTS - 1));
                end
            endcase
        endfunction

        function void check_beat(rdcs_pkg::t_result got);
            rdcs_pkg::t_result exp;
            if (expected_beats.size() == 0) begin
                flag($sformatf("unexpected beat kind=%0d slot=%0d", got.kind, got.digit_slot));
                return;
            end
            exp = expected_beats.pop_front();
            if (got.kind !== exp.kind || got.clear_screen !== exp.clear_screen ||
                got.digit_slot !== exp.digit_slot || got.shown_char !== exp.shown_char ||
                got.target_char !== exp.target_char || got.frame !== exp.frame ||
                got.rolling !== exp.rolling || got.last !== exp.last)
                flag({$sformatf("exp kind=%0d clr=%0d slot=%0d shown=%0d tgt=%0d frm=%0d roll=%0d last=%0d",
                                exp.kind, exp.clear_screen, exp.digit_slot, exp.shown_char,
                                exp.target_char, exp.frame, exp.rolling, exp.last),
                      $sformatf(" | got kind=%0d clr=%0d slot=%0d shown=%0d tgt=%0d frm=%0d roll=%0d last=%0d",
                                got.kind, got.clear_screen, got.digit_slot, got.shown_char,
                                got.target_char, got.frame, got.rolling, got.last)});
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // hours[4:0], minutes[10:5], zero pad
    logic [1:0]  s_tuser;   // mode[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // clear_screen[0], digit_slot[2:1], shown_char[6:3],
                            // target_char[10:7], frame[13:11], rolling[14], pad
    logic        m_tuser;   // kind[0]
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    digit_roll_scoreboard sb;
    int                   src_idle_pct;
    int                   snk_idle_pct;
    rdcs_pkg::t_result    out_beat;

    rolling_digit_clock_sequencer #(.MAX_STEPS(ROLL_STEPS)) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Both handshakes are sampled on the edge that completes them.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready)
                sb.note_item(rdcs_pkg::t_mode'(s_tuser), s_tdata[4:0], s_tdata[10:5]);
            if (m_tvalid && m_tready) begin
                out_beat.kind         = m_tuser;
                out_beat.clear_screen = m_tdata[0];
                out_beat.digit_slot   = m_tdata[2:1];
                out_beat.shown_char   = m_tdata[6:3];
                out_beat.target_char  = m_tdata[10:7];
                out_beat.frame        = m_tdata[13:11];
                out_beat.rolling      = m_tdata[14];
                out_beat.last         = m_tlast;
                sb.check_beat(out_beat);
            end
        end
    end

    task automatic send_item(input rdcs_pkg::t_mode md, input int hrs, input int mins);
        logic [rdcs_pkg::HOURS_W-1:0]   h;
        logic [rdcs_pkg::MINUTES_W-1:0] m;
        h = hrs[rdcs_pkg::HOURS_W-1:0];
        m = mins[rdcs_pkg::MINUTES_W-1:0];
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= {5'd0, m, h};
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Write the format register, then read it back.
    task automatic write_format(input logic [rdcs_pkg::FMT_W-1:0] value);
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_FORMAT;
        pwdata  <= {{(32-rdcs_pkg::FMT_W){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.fmt = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd !== {{(32-rdcs_pkg::FMT_W){1'b0}}, value})
            sb.flag($sformatf("format readback exp=%0d got=%0h", value, rd));
    endtask

    function automatic int rand_hours();
        return ($urandom_range(99) < 85) ? $urandom_range(23) : $urandom_range(31);
    endfunction

    function automatic int rand_minutes();
        return ($urandom_range(99) < 85) ? $urandom_range(59) : $urandom_range(63);
    endfunction

    // Mostly load-then-roll sequences with scattered redraws, plus loose items.
    task automatic run_random(input int count);
        int sent;
        int steps;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 70) begin
                send_item(($urandom_range(99) < 80) ? rdcs_pkg::MODE_UPDATE
                                                    : rdcs_pkg::MODE_SET,
                          rand_hours(), rand_minutes());
                sent++;
                steps = $urandom_range(1, 36);
                if (steps > count - sent) steps = count - sent;
                repeat (steps) begin
                    send_item(($urandom_range(99) < 10) ? rdcs_pkg::MODE_REDRAW
                                                        : rdcs_pkg::MODE_STEP,
                              $urandom_range(31), $urandom_range(63));
                    sent++;
                end
            end else begin
                send_item(rdcs_pkg::t_mode'($urandom_range(3)), rand_hours(), rand_minutes());
                sent++;
            end
        end
    endtask

    initial begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        sb           = new();
        src_idle_pct = 11;
        snk_idle_pct = 55;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= rdcs_pkg::MODE_SET;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= ADDR_FORMAT;
        pwdata   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_format(rdcs_pkg::FMT_24H);

        // directed: reset view, idle step, saturation, partial and full roll
        send_item(rdcs_pkg::MODE_REDRAW, 0, 0);
        send_item(rdcs_pkg::MODE_STEP, 0, 0);
        send_item(rdcs_pkg::MODE_SET, 31, 63);
        send_item(rdcs_pkg::MODE_REDRAW, 0, 0);
        send_item(rdcs_pkg::MODE_UPDATE, 0, 0);
        repeat (3) send_item(rdcs_pkg::MODE_STEP, 0, 0);
        send_item(rdcs_pkg::MODE_REDRAW, 0, 0);
        send_item(rdcs_pkg::MODE_SET, 12, 34);
        send_item(rdcs_pkg::MODE_UPDATE, 12, 35);
        repeat (ROLL_STEPS + 1) send_item(rdcs_pkg::MODE_STEP, 31, 63);
        send_item(rdcs_pkg::MODE_SET, 20, 5);
        send_item(rdcs_pkg::MODE_REDRAW, 0, 0);
        // hour tens index 2 has no image in 12-hour form
        wait_drained();
        write_format(rdcs_pkg::FMT_12H_ZERO);
        send_item(rdcs_pkg::MODE_REDRAW, 0, 0);
        send_item(rdcs_pkg::MODE_SET, 0, 0);

        run_random(70);
        wait_drained();
        run_random(70);

        src_idle_pct = 55;
        snk_idle_pct = 11;
        wait_drained();
        write_format(FMT_ALIAS);
        run_random(70);
        wait_drained();
        write_format(FMT_12H_BLANK);
        run_random(70);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        wait_drained();
        write_format(rdcs_pkg::FMT_24H);
        run_random(106);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
